>>> rtl/wsa_pkg.sv
// Package for the windowed aggregator: lane types, constants, command and status structs.
// Used by every module of the block; depends on nothing.
package wsa_pkg;

  localparam int Lanes = 4;
  localparam int LaneW = $clog2(Lanes);
  localparam int CfgIdxW = 3;

  localparam logic [2:0] T_BOOL = 3'd0;
  localparam logic [2:0] T_U32  = 3'd1;
  localparam logic [2:0] T_U64  = 3'd2;
  localparam logic [2:0] T_I32  = 3'd3;
  localparam logic [2:0] T_I64  = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_START  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LENGTH = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TYPE0  = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT,
    ST_ADD
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic take;       // capture an incoming request
    logic div_start;  // load the divider
    logic div_step;   // one quotient bit
    logic emit_next;  // present next lane result
    logic close;      // advance window and clear accumulators
    logic add;        // accumulate the held record
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic eod;
    logic late;
    logic crosses;
    logic has_records;
    logic div_done;
    logic out_busy;
    logic last_lane;
  } stat_t;

  function automatic logic [2:0] eff_type(input logic [2:0] t);
    eff_type = (t > T_I64) ? T_U64 : t;
  endfunction

  function automatic logic [63:0] type_max(input logic [2:0] t);
    case (eff_type(t))
      T_BOOL:  type_max = 64'd1;
      T_U32:   type_max = 64'h0000_0000_FFFF_FFFF;
      T_I32:   type_max = 64'h0000_0000_7FFF_FFFF;
      T_I64:   type_max = 64'h7FFF_FFFF_FFFF_FFFF;
      default: type_max = '1;
    endcase
  endfunction

  function automatic logic [63:0] type_min(input logic [2:0] t);
    case (eff_type(t))
      T_I32:   type_min = 64'hFFFF_FFFF_8000_0000;
      T_I64:   type_min = 64'h8000_0000_0000_0000;
      default: type_min = '0;
    endcase
  endfunction

  function automatic logic [63:0] norm_value(input logic [2:0] t, input logic [63:0] v);
    case (eff_type(t))
      T_BOOL:  norm_value = {56'd0, v[7:0]};
      T_U32:   norm_value = {32'd0, v[31:0]};
      T_I32:   norm_value = {{32{v[31]}}, v[31:0]};
      default: norm_value = v;
    endcase
  endfunction

  function automatic logic typed_less(input logic [2:0] t, input logic [63:0] a,
                                      input logic [63:0] b);
    logic sg;
    sg = (eff_type(t) == T_I32) || (eff_type(t) == T_I64);
    typed_less = ({a[63] ^ sg, a[62:0]} < {b[63] ^ sg, b[62:0]});
  endfunction

endpackage

>>> rtl/wsa_ctrl.sv
// Controller state machine for the windowed aggregator.
// Depends on wsa_pkg for state, command and status types.
module wsa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  wsa_pkg::stat_t stat,
  output wsa_pkg::cmd_t  cmd
);
  import wsa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (stat.eod) begin
          state_next = stat.has_records ? ST_EMIT : ST_IDLE;
        end else if (stat.late) begin
          state_next = ST_IDLE;
        end else if (stat.crosses) begin
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_ADD;
        end
      end
      ST_DIVIDE: if (stat.div_done) state_next = ST_EMIT;
      ST_EMIT: begin
        if (!stat.out_busy && stat.last_lane) begin
          state_next = stat.eod ? ST_IDLE : ST_ADD;
        end
      end
      ST_ADD: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE: cmd.take = in_valid;
      ST_CHECK: cmd.div_start = !stat.eod && !stat.late && stat.crosses;
      ST_DIVIDE: cmd.div_step = !stat.div_done;
      ST_EMIT: begin
        cmd.emit_next = !stat.out_busy;
        cmd.close = !stat.out_busy && stat.last_lane;
      end
      ST_ADD: cmd.add = 1'b1;
      default: cmd = '0;
    endcase
  end

  // A close always happens while emitting the last lane.
  assert property (@(posedge clk) disable iff (rst) cmd.close |-> state == ST_EMIT);
  // After an accumulation the controller is ready again.
  assert property (@(posedge clk) disable iff (rst) state == ST_ADD |=> state == ST_IDLE);
  // Only one request enters at a time.
  assert property (@(posedge clk) disable iff (rst) cmd.take |=> in_stall);
endmodule

>>> rtl/wsa_datapath.sv
// Datapath for the windowed aggregator: configuration, accumulators,
// a restoring bit-serial divider and the output register. Depends on wsa_pkg.
module wsa_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  wsa_pkg::cmd_t             cmd,
  output wsa_pkg::stat_t            stat,
  input  logic [63:0]               time_ns,
  input  logic [63:0]               value_0,
  input  logic [63:0]               value_1,
  input  logic [63:0]               value_2,
  input  logic [63:0]               value_3,
  input  logic [3:0]                null_mask,
  input  logic                      end_of_data,
  input  logic                      cfg_valid,
  input  logic [wsa_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]               cfg_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [63:0]               window_begin,
  output logic [1:0]                lane_index,
  output logic [63:0]               lane_sum,
  output logic [63:0]               lane_min,
  output logic [63:0]               lane_max,
  output logic [31:0]               lane_count,
  output logic [63:0]               empty_windows_after,
  output logic                      last_of_window
);
  import wsa_pkg::*;

  logic [63:0] window_length;
  logic [2:0]  lane_type [Lanes];
  logic [63:0] open_time;
  logic [63:0] sums [Lanes];
  logic [63:0] mins [Lanes];
  logic [63:0] maxs [Lanes];
  logic [31:0] counts [Lanes];
  logic        has_rec;

  logic [63:0] h_time;
  logic [63:0] h_val [Lanes];
  logic [3:0]  h_null;
  logic        h_eod;

  logic [63:0] len, delta;
  logic [63:0] quo, rem, dvd;
  logic [6:0]  div_cnt;
  logic [63:0] skip;
  logic [LaneW-1:0] lane;
  logic        emitted_last;
  logic [64:0] trial;

  assign len = (window_length == '0) ? 64'd1 : window_length;
  assign delta = h_time - open_time;
  assign trial = {rem, dvd[63]};

  assign stat.eod = h_eod;
  assign stat.late = h_time < open_time;
  assign stat.crosses = delta >= len;
  assign stat.has_records = has_rec;
  assign stat.div_done = div_cnt[6];
  assign stat.out_busy = out_valid && out_stall;
  assign stat.last_lane = (lane == LaneW'(Lanes - 1));

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      h_time <= time_ns;
      h_val[0] <= value_0;
      h_val[1] <= value_1;
      h_val[2] <= value_2;
      h_val[3] <= value_3;
      h_null <= null_mask;
      h_eod <= end_of_data;
    end
  end

  // Restoring divider: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= 7'd64;
    end else if (cmd.div_start) begin
      div_cnt <= '0;
      dvd <= delta;
      rem <= '0;
      quo <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 7'd1;
      dvd <= {dvd[62:0], 1'b0};
      if (trial >= {1'b0, len}) begin
        rem <= 64'(trial - {1'b0, len});
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= trial[63:0];
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  // Window advance is delta - rem = k * len, or len at end of data.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= 64'd1000000000;
      open_time <= '0;
      has_rec <= 1'b0;
      for (int i = 0; i < Lanes; i++) begin
        lane_type[i] <= T_U64;
        sums[i] <= '0;
        counts[i] <= '0;
        mins[i] <= '1;
        maxs[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == REG_START) begin
        open_time <= cfg_data;
        has_rec <= 1'b0;
        for (int i = 0; i < Lanes; i++) begin
          sums[i] <= '0;
          counts[i] <= '0;
          mins[i] <= type_max(lane_type[i]);
          maxs[i] <= type_min(lane_type[i]);
        end
      end else if (cfg_index == REG_LENGTH) begin
        window_length <= cfg_data;
      end else begin
        for (int i = 0; i < Lanes; i++) begin
          if (cfg_index == CfgIdxW'(i + 2)) begin
            lane_type[i] <= cfg_data[2:0];
            mins[i] <= type_max(cfg_data[2:0]);
            maxs[i] <= type_min(cfg_data[2:0]);
          end
        end
      end
    end else if (cmd.close) begin
      open_time <= h_eod ? open_time + len : h_time - rem;
      has_rec <= 1'b0;
      for (int i = 0; i < Lanes; i++) begin
        sums[i] <= '0;
        counts[i] <= '0;
        mins[i] <= type_max(lane_type[i]);
        maxs[i] <= type_min(lane_type[i]);
      end
    end else if (cmd.add) begin
      has_rec <= 1'b1;
      for (int i = 0; i < Lanes; i++) begin
        if (!h_null[i]) begin
          sums[i] <= sums[i] + norm_value(lane_type[i], h_val[i]);
          if (typed_less(lane_type[i], norm_value(lane_type[i], h_val[i]), mins[i]))
            mins[i] <= norm_value(lane_type[i], h_val[i]);
          if (typed_less(lane_type[i], maxs[i], norm_value(lane_type[i], h_val[i])))
            maxs[i] <= norm_value(lane_type[i], h_val[i]);
          if (counts[i] != '1) counts[i] <= counts[i] + 32'd1;
        end
      end
    end
  end

  assign skip = h_eod ? 64'd0 : quo - 64'd1;

  // Output register; the lane counter walks the lanes while emitting.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      lane <= '0;
      emitted_last <= 1'b0;
    end else begin
      if (cmd.emit_next) begin
        out_valid <= 1'b1;
        window_begin <= open_time;
        lane_index <= 2'(lane);
        lane_sum <= sums[lane];
        lane_min <= mins[lane];
        lane_max <= maxs[lane];
        lane_count <= counts[lane];
        empty_windows_after <= skip;
        last_of_window <= stat.last_lane;
        emitted_last <= stat.last_lane;
        lane <= stat.last_lane ? '0 : lane + LaneW'(1);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Closing a window happens only with the last lane's result.
  assert property (@(posedge clk) disable iff (rst) cmd.close |-> cmd.emit_next && stat.last_lane);
  // A lane result is marked last exactly when it was the last lane.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit_next |=> out_valid && (last_of_window == emitted_last));
  // The divider is never restarted while it runs.
  assert property (@(posedge clk) disable iff (rst) cmd.div_step |-> !cmd.div_start);
endmodule

>>> rtl/windowed_sum_min_max_aggregator.sv
// Top level of the tumbling-window sum/min/max/count aggregator.
// Depends on wsa_pkg, wsa_ctrl and wsa_datapath.
//
// One request is handled at a time. A record inside the open window is
// captured, checked and accumulated. A record that closes a window also
// runs the bit-serial divider (64 quotient bits) to count skipped windows,
// then emits one result per lane at up to one per cycle while the output
// does not stall, and then accumulates the record. End of data on a window
// with records emits the lanes without the divider. Configuration writes
// are always ready and must be made while the block is idle.
module windowed_sum_min_max_aggregator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] time_ns,
  input  logic [63:0] value_0,
  input  logic [63:0] value_1,
  input  logic [63:0] value_2,
  input  logic [63:0] value_3,
  input  logic [3:0]  null_mask,
  input  logic        end_of_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [wsa_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] window_begin,
  output logic [1:0]  lane_index,
  output logic [63:0] lane_sum,
  output logic [63:0] lane_min,
  output logic [63:0] lane_max,
  output logic [31:0] lane_count,
  output logic [63:0] empty_windows_after,
  output logic        last_of_window
);
  import wsa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  wsa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  wsa_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .time_ns(time_ns), .value_0(value_0), .value_1(value_1),
    .value_2(value_2), .value_3(value_3), .null_mask(null_mask),
    .end_of_data(end_of_data),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .window_begin(window_begin), .lane_index(lane_index), .lane_sum(lane_sum),
    .lane_min(lane_min), .lane_max(lane_max), .lane_count(lane_count),
    .empty_windows_after(empty_windows_after), .last_of_window(last_of_window)
  );
endmodule
